/* src/tled_pkg.sv */
package tled_pkg;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_TXDONE = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] KIND_INPUT    = 2'd0;
  localparam logic [1:0] KIND_ECHO     = 2'd1;
  localparam logic [1:0] KIND_OUTPUT   = 2'd2;
  localparam logic [1:0] KIND_PRIORITY = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RX,
    OP_ERASE,
    OP_TXDONE,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ2,
    S_DATA,
    S_PUSH,
    S_EMIT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] port;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic        read_valid;
    logic [7:0]  read_char;
    logic        end_of_line;
    logic [10:0] lines_ready;
    logic        write_refused;
    logic        all_sent;
  } result_t;

endpackage

/* src/tled_ram.sv */
module tled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/tled_fifo.sv */
module tled_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  // DEPTH is a power of two so the pointers wrap on their own.
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? PW'(wptr_q + 1'b1) : wptr_q;
    rptr_d = do_rd ? PW'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* src/tled_front.sv */
module tled_front #(
  parameter int TERMINAL_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      cmd_i,
  input  logic [1:0]      port_i,
  input  logic [7:0]      char_in_i,
  input  logic            item_pop_i,
  output logic            item_valid_o,
  output tled_pkg::item_t item_o
);
  import tled_pkg::*;

  item_t cls;
  logic  empty_w;

  // Classify the beat before it is queued, so the back end sees one opcode.
  always_comb begin
    cls.port = port_i;
    cls.ch   = char_in_i;
    cls.op   = OP_NONE;
    if (32'(port_i) < TERMINAL_COUNT) begin
      unique case (cmd_i)
        CMD_RX: begin
          if (char_in_i == CH_BS || char_in_i == CH_DEL) begin
            cls.op = OP_ERASE;
          end else begin
            cls.op = OP_RX;
            if (char_in_i == CH_CR) begin
              cls.ch = CH_LF;
            end
          end
        end
        CMD_TXDONE: cls.op = OP_TXDONE;
        CMD_WRITE:  cls.op = OP_WRITE;
        CMD_READ:   cls.op = OP_READ;
        default:    cls.op = OP_NONE;
      endcase
    end
  end

  tled_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .full_o (full),
    .wdata_i(cls),
    .rd_i   (item_pop_i),
    .empty_o(empty_w),
    .rdata_o(item_o)
  );

  assign item_valid_o = !empty_w;

endmodule

/* src/tled_back.sv */
module tled_back #(
  parameter int RING_DEPTH     = 1024,
  parameter int TERMINAL_COUNT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  tled_pkg::item_t   item_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output tled_pkg::result_t res_o
);
  import tled_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int TW = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
  localparam int AW = TW + PW;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [PW-1:0] prev_pos(input logic [PW-1:0] p);
    return (p == '0) ? PW'(RING_DEPTH - 1) : PW'(p - 1'b1);
  endfunction

  state_e        st_q, st_d;
  item_t         item_q, item_d;
  result_t       res_q, res_d;
  logic [1:0]    kind_q, kind_d;
  logic [1:0]    pn_q, pn_d;
  logic [7:0]    pb_q [3];
  logic [7:0]    pb_d [3];

  logic [PW-1:0] head_q [TERMINAL_COUNT][4];
  logic [PW-1:0] head_d [TERMINAL_COUNT][4];
  logic [PW-1:0] tail_q [TERMINAL_COUNT][4];
  logic [PW-1:0] tail_d [TERMINAL_COUNT][4];
  logic [CW-1:0] cnt_q  [TERMINAL_COUNT][4];
  logic [CW-1:0] cnt_d  [TERMINAL_COUNT][4];
  logic [CW-1:0] lines_q [TERMINAL_COUNT];
  logic [CW-1:0] lines_d [TERMINAL_COUNT];
  logic          busy_q [TERMINAL_COUNT];
  logic          busy_d [TERMINAL_COUNT];

  logic          we    [4];
  logic [AW-1:0] waddr [4];
  logic [7:0]    wdata [4];
  logic          re    [4];
  logic [AW-1:0] raddr [4];
  logic [7:0]    rdata [4];

  logic [TW-1:0] t;
  logic          in_empty, in_full, echo_full, out_full;
  logic          pri_nonempty, echo_nonempty, out_nonempty;
  logic          start;

  assign t             = TW'(item_q.port);
  assign in_empty      = (cnt_q[t][KIND_INPUT] == '0);
  assign in_full       = (cnt_q[t][KIND_INPUT] == CW'(RING_DEPTH));
  assign echo_full     = (cnt_q[t][KIND_ECHO] == CW'(RING_DEPTH));
  assign out_full      = (cnt_q[t][KIND_OUTPUT] == CW'(RING_DEPTH));
  assign pri_nonempty  = (cnt_q[t][KIND_PRIORITY] != '0);
  assign echo_nonempty = (cnt_q[t][KIND_ECHO] != '0);
  assign out_nonempty  = (cnt_q[t][KIND_OUTPUT] != '0);
  assign start         = (st_q == S_IDLE) && item_valid_i && !res_full_i;

  for (genvar g = 0; g < 4; g++) begin : g_ring
    tled_ram #(
      .WIDTH(8),
      .DEPTH(1 << AW)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[g]),
      .waddr_i(waddr[g]),
      .wdata_i(wdata[g]),
      .re_i   (re[g]),
      .raddr_i(raddr[g]),
      .rdata_o(rdata[g])
    );
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (start) st_d = S_EXEC;
      S_EXEC: begin
        unique case (item_q.op)
          OP_ERASE:  st_d = in_empty ? S_EMIT : S_DATA;
          OP_RX:     st_d = (in_full && item_q.ch == CH_LF) ? S_DATA : S_EMIT;
          OP_TXDONE: st_d = (pri_nonempty || echo_nonempty || out_nonempty) ? S_DATA : S_EMIT;
          OP_WRITE:  st_d = (out_full || busy_q[t]) ? S_EMIT : S_READ2;
          OP_READ:   st_d = (lines_q[t] != '0 && !in_empty) ? S_DATA : S_EMIT;
          default:   st_d = S_EMIT;
        endcase
      end
      S_READ2: st_d = S_DATA;
      S_DATA:  st_d = (item_q.op == OP_ERASE) ? S_PUSH : S_EMIT;
      S_PUSH:  st_d = (pn_q == 2'd1) ? S_EMIT : S_PUSH;
      S_EMIT:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Datapath and ring bookkeeping.
  always_comb begin
    logic          pri_en;
    logic [7:0]    pri_ch;
    logic [7:0]    c;
    logic [PW-1:0] last;

    item_d  = item_q;
    res_d   = res_q;
    kind_d  = kind_q;
    pn_d    = pn_q;
    pb_d    = pb_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    lines_d = lines_q;
    busy_d  = busy_q;
    pri_en  = 1'b0;
    pri_ch  = CH_LF;
    c       = rdata[kind_q];
    last    = prev_pos(tail_q[t][KIND_INPUT]);
    for (int k = 0; k < 4; k++) begin
      we[k]    = 1'b0;
      waddr[k] = '0;
      wdata[k] = '0;
      re[k]    = 1'b0;
      raddr[k] = '0;
    end
    item_pop_o = start;
    res_push_o = (st_q == S_EMIT);
    res_o      = res_q;
    res_o.lines_ready = (item_q.op == OP_NONE) ? '0 : 11'(lines_q[t]);

    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          item_d = item_i;
          res_d  = '0;
        end
      end
      S_EXEC: begin
        unique case (item_q.op)
          OP_ERASE: begin
            if (!in_empty) begin
              kind_d = KIND_INPUT;
              re[KIND_INPUT]    = 1'b1;
              raddr[KIND_INPUT] = {t, last};
            end
          end
          OP_RX: begin
            if (!in_full) begin
              we[KIND_INPUT]    = 1'b1;
              waddr[KIND_INPUT] = {t, tail_q[t][KIND_INPUT]};
              wdata[KIND_INPUT] = item_q.ch;
              tail_d[t][KIND_INPUT] = next_pos(tail_q[t][KIND_INPUT]);
              cnt_d[t][KIND_INPUT]  = cnt_q[t][KIND_INPUT] + 1'b1;
              if (item_q.ch == CH_LF) begin
                lines_d[t] = lines_q[t] + 1'b1;
              end
            end else if (item_q.ch == CH_LF) begin
              kind_d = KIND_INPUT;
              re[KIND_INPUT]    = 1'b1;
              raddr[KIND_INPUT] = {t, last};
            end
            if (!echo_full) begin
              if (!busy_q[t]) begin
                busy_d[t]      = 1'b1;
                res_d.tx_valid = 1'b1;
                res_d.tx_char  = (item_q.ch == CH_LF) ? CH_CR : item_q.ch;
                pri_en         = (item_q.ch == CH_LF);
              end else begin
                we[KIND_ECHO]    = 1'b1;
                waddr[KIND_ECHO] = {t, tail_q[t][KIND_ECHO]};
                wdata[KIND_ECHO] = item_q.ch;
                tail_d[t][KIND_ECHO] = next_pos(tail_q[t][KIND_ECHO]);
                cnt_d[t][KIND_ECHO]  = cnt_q[t][KIND_ECHO] + 1'b1;
              end
            end
          end
          OP_TXDONE: begin
            busy_d[t] = 1'b0;
            kind_d    = KIND_OUTPUT;
            if (pri_nonempty) begin
              kind_d = KIND_PRIORITY;
            end else if (echo_nonempty) begin
              kind_d = KIND_ECHO;
            end
            if (pri_nonempty || echo_nonempty || out_nonempty) begin
              busy_d[t]          = 1'b1;
              re[kind_d]         = 1'b1;
              raddr[kind_d]      = {t, head_q[t][kind_d]};
              head_d[t][kind_d]  = next_pos(head_q[t][kind_d]);
              cnt_d[t][kind_d]   = cnt_q[t][kind_d] - 1'b1;
            end else begin
              res_d.all_sent = 1'b1;
            end
          end
          OP_WRITE: begin
            if (out_full) begin
              res_d.write_refused = 1'b1;
            end else begin
              we[KIND_OUTPUT]    = 1'b1;
              waddr[KIND_OUTPUT] = {t, tail_q[t][KIND_OUTPUT]};
              wdata[KIND_OUTPUT] = item_q.ch;
              tail_d[t][KIND_OUTPUT] = next_pos(tail_q[t][KIND_OUTPUT]);
              cnt_d[t][KIND_OUTPUT]  = cnt_q[t][KIND_OUTPUT] + 1'b1;
            end
          end
          OP_READ: begin
            if (lines_q[t] != '0 && !in_empty) begin
              kind_d = KIND_INPUT;
              re[KIND_INPUT]    = 1'b1;
              raddr[KIND_INPUT] = {t, head_q[t][KIND_INPUT]};
              head_d[t][KIND_INPUT] = next_pos(head_q[t][KIND_INPUT]);
              cnt_d[t][KIND_INPUT]  = cnt_q[t][KIND_INPUT] - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ2: begin
        // The byte just written may be the oldest one, so it is read in the next state, S_READ2.
        kind_d = KIND_OUTPUT;
        busy_d[t] = 1'b1;
        re[KIND_OUTPUT]    = 1'b1;
        raddr[KIND_OUTPUT] = {t, head_q[t][KIND_OUTPUT]};
        head_d[t][KIND_OUTPUT] = next_pos(head_q[t][KIND_OUTPUT]);
        cnt_d[t][KIND_OUTPUT]  = cnt_q[t][KIND_OUTPUT] - 1'b1;
      end
      S_DATA: begin
        unique case (item_q.op)
          OP_ERASE: begin
            if (c == CH_LF && lines_q[t] != '0) begin
              lines_d[t] = lines_q[t] - 1'b1;
            end
            tail_d[t][KIND_INPUT] = last;
            cnt_d[t][KIND_INPUT]  = cnt_q[t][KIND_INPUT] - 1'b1;
            if (busy_q[t]) begin
              pb_d[0] = CH_BS;
              pb_d[1] = CH_SP;
              pb_d[2] = CH_BS;
              pn_d    = 2'd3;
            end else begin
              pb_d[0] = CH_SP;
              pb_d[1] = CH_BS;
              pn_d    = 2'd2;
              busy_d[t]      = 1'b1;
              res_d.tx_valid = 1'b1;
              res_d.tx_char  = CH_BS;
            end
          end
          OP_RX: begin
            // Full ring: the newline replaces the last stored byte.
            if (c != CH_LF) begin
              lines_d[t] = lines_q[t] + 1'b1;
            end
            we[KIND_INPUT]    = 1'b1;
            waddr[KIND_INPUT] = {t, last};
            wdata[KIND_INPUT] = CH_LF;
          end
          OP_READ: begin
            res_d.read_valid  = 1'b1;
            res_d.read_char   = c;
            res_d.end_of_line = (c == CH_LF);
            if (c == CH_LF && lines_q[t] != '0) begin
              lines_d[t] = lines_q[t] - 1'b1;
            end
          end
          default: begin
            res_d.tx_valid = 1'b1;
            if (kind_q == KIND_PRIORITY) begin
              res_d.tx_char = c;
            end else begin
              res_d.tx_char = (c == CH_LF) ? CH_CR : c;
              pri_en        = (c == CH_LF);
            end
          end
        endcase
      end
      S_PUSH: begin
        pri_en  = 1'b1;
        pri_ch  = pb_q[0];
        pb_d[0] = pb_q[1];
        pb_d[1] = pb_q[2];
        pn_d    = pn_q - 1'b1;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase

    if (pri_en && cnt_q[t][KIND_PRIORITY] != CW'(RING_DEPTH)) begin
      we[KIND_PRIORITY]    = 1'b1;
      waddr[KIND_PRIORITY] = {t, tail_q[t][KIND_PRIORITY]};
      wdata[KIND_PRIORITY] = pri_ch;
      tail_d[t][KIND_PRIORITY] = next_pos(tail_q[t][KIND_PRIORITY]);
      cnt_d[t][KIND_PRIORITY]  = cnt_q[t][KIND_PRIORITY] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      pn_q <= '0;
      for (int i = 0; i < TERMINAL_COUNT; i++) begin
        lines_q[i] <= '0;
        busy_q[i]  <= 1'b0;
        for (int k = 0; k < 4; k++) begin
          head_q[i][k] <= '0;
          tail_q[i][k] <= '0;
          cnt_q[i][k]  <= '0;
        end
      end
    end else begin
      st_q    <= st_d;
      pn_q    <= pn_d;
      lines_q <= lines_d;
      busy_q  <= busy_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    kind_q <= kind_d;
    pb_q   <= pb_d;
  end

endmodule

/* src/terminal_echo_line_discipline_core.sv */
// Channel   Handshake             Payload
// input     push / full           cmd_i, port_i, char_in_i
// result    empty / pop           tx_valid_o, tx_char_o, read_valid_o, read_char_o,
//                                 end_of_line_o, lines_ready_o, write_refused_o,
//                                 all_sent_o
//
// One beat is in the back end at a time: it starts, issues writes and a ring read
// (a write reads the output ring in a further state), takes the registered read
// data, makes up to three priority ring writes for an erase (one RAM write port
// per ring), and queues the result. Each input beat yields exactly one result beat.
// Reset (rst_ni, asynchronous, active low) empties all rings and queues at once.
// A full result queue stalls the back end; a full input queue raises full.
module terminal_echo_line_discipline_core #(
  parameter int RING_DEPTH     = 1024,
  parameter int TERMINAL_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  port_i,
  input  logic [7:0]  char_in_i,
  output logic        empty,
  input  logic        pop,
  output logic        tx_valid_o,
  output logic [7:0]  tx_char_o,
  output logic        read_valid_o,
  output logic [7:0]  read_char_o,
  output logic        end_of_line_o,
  output logic [10:0] lines_ready_o,
  output logic        write_refused_o,
  output logic        all_sent_o
);
  import tled_pkg::*;

  item_t   item;
  logic    item_valid, item_pop;
  result_t res, res_head;
  logic    res_push, res_full;

  // The front end classifies each beat (erase, CR mapping, port range) and
  // queues it so the sender is not held while the back end works.
  tled_front #(
    .TERMINAL_COUNT(TERMINAL_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .port_i      (port_i),
    .char_in_i   (char_in_i),
    .item_pop_i  (item_pop),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  // The back end owns the ring RAMs, pointers, line counts and transmitter
  // state, and only starts a beat when the result queue has room.
  tled_back #(
    .RING_DEPTH    (RING_DEPTH),
    .TERMINAL_COUNT(TERMINAL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue decouples the back end from the consumer.
  tled_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_push),
    .full_o (res_full),
    .wdata_i(res),
    .rd_i   (pop),
    .empty_o(empty),
    .rdata_o(res_head)
  );

  assign tx_valid_o      = res_head.tx_valid;
  assign tx_char_o       = res_head.tx_char;
  assign read_valid_o    = res_head.read_valid;
  assign read_char_o     = res_head.read_char;
  assign end_of_line_o   = res_head.end_of_line;
  assign lines_ready_o   = res_head.lines_ready;
  assign write_refused_o = res_head.write_refused;
  assign all_sent_o      = res_head.all_sent;

endmodule
